/* rtl/core/ffca_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the first-fit chunk allocator.
// Depends on nothing; the top level and the testbench use it by scoped names.
package ffca_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int USED_ENTRIES = 16;

  localparam int FREE_IDX_W = $clog2(FREE_ENTRIES);
  localparam int USED_IDX_W = $clog2(USED_ENTRIES);
  localparam int FREE_CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int USED_CNT_W = $clog2(USED_ENTRIES + 1);
  localparam int PTR_W = (FREE_CNT_W > USED_CNT_W) ? FREE_CNT_W : USED_CNT_W;

  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE_ADDR = 2'd1;
  localparam logic [1:0] CMD_FREE_LAST = 2'd2;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED     = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOCATED = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE     = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL    = 3'd4;

  localparam logic [0:0] REG_HEAP_BASE  = 1'd0;
  localparam logic [0:0] REG_HEAP_LIMIT = 1'd1;

  localparam logic [9:0] MAX_REQUEST = 10'd512;

  typedef struct packed {
    logic [31:0] base;
    logic [2:0]  cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [9:0] class_bytes(input logic [2:0] c);
    class_bytes = 10'd32 << c;
  endfunction

  function automatic logic [2:0] class_for(input logic [9:0] req);
    if (req <= 10'd32) begin
      class_for = 3'd0;
    end else if (req <= 10'd64) begin
      class_for = 3'd1;
    end else if (req <= 10'd128) begin
      class_for = 3'd2;
    end else if (req <= 10'd256) begin
      class_for = 3'd3;
    end else begin
      class_for = 3'd4;
    end
  endfunction

endpackage

/* rtl/core/first_fit_chunk_allocator.sv */
`timescale 1ns / 1ps
// Top level of the first-fit chunk allocator: command sequencer and list RAMs.
// Depends on ffca_pkg and ffca_list_ram.
//
// Usage: an item on the input channel (valid/ready) carries a command: allocate,
// free by address, or free the most recent allocation. Exactly one result item
// leaves on the output channel (valid/ready) for each input item.
// The free list and the allocated list sit in two synchronous RAMs. A command
// scans its list one entry at a time, in a read state and then a check state,
// and a removal closes the gap by moving each later entry down one place, again
// with a read state and a write state per moved entry. Each entry needs a read
// state of its own because each list RAM has a single read port.
// A finished result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls while a second result is ready, the sequencer
// holds that result until the output register frees.
// Configuration writes (heap base, heap limit) must come only while the block is
// idle; the block does not enforce it. A heap base write reloads the bump pointer.
// Reset empties both lists, sets the bump pointer to zero and the limit to 65536.
// No clearing pass is needed after reset.
module first_fit_chunk_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  request_bytes_i,
  input  logic [31:0] chunk_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] granted_address_o,
  output logic [9:0]  chunk_bytes_o,
  output logic [2:0]  status_o
);

  localparam int PW = ffca_pkg::PTR_W;
  localparam int FIW = ffca_pkg::FREE_IDX_W;
  localparam int UIW = ffca_pkg::USED_IDX_W;
  localparam int FCW = ffca_pkg::FREE_CNT_W;
  localparam int UCW = ffca_pkg::USED_CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_CK = 3'd2;
  localparam logic [2:0] S_CMP_RD  = 3'd3;
  localparam logic [2:0] S_CMP_WR  = 3'd4;
  localparam logic [2:0] S_PUSH    = 3'd5;
  localparam logic [2:0] S_BUMP    = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] cmd_q, cmd_d;
  logic [9:0] req_q, req_d;
  logic [31:0] addr_q, addr_d;
  logic [PW-1:0] scan_q, scan_d;
  logic [FCW-1:0] free_cnt_q, free_cnt_d;
  logic [UCW-1:0] used_cnt_q, used_cnt_d;
  logic [31:0] heap_base_q, heap_base_d, heap_limit_q, heap_limit_d, brk_q, brk_d;
  ffca_pkg::entry_t ent_q, ent_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [9:0] res_bytes_q, res_bytes_d;
  logic [2:0] res_st_q, res_st_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [9:0] out_bytes_q, out_bytes_d;
  logic [2:0] out_st_q, out_st_d;

  logic f_we, u_we;
  logic [FIW-1:0] f_waddr, f_raddr;
  logic [UIW-1:0] u_waddr, u_raddr;
  ffca_pkg::entry_t f_wdata, u_wdata, f_rdata, u_rdata, rd_ent;

  logic use_used;
  logic [PW-1:0] list_cnt, scan_p1, scan_p2, rd_ptr;
  logic free_full, used_full, hit;
  logic [2:0] new_cls;
  logic [9:0] new_cap;
  logic [32:0] new_end;

  ffca_list_ram #(.DEPTH(ffca_pkg::FREE_ENTRIES), .WIDTH(ffca_pkg::ENTRY_W)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  ffca_list_ram #(.DEPTH(ffca_pkg::USED_ENTRIES), .WIDTH(ffca_pkg::ENTRY_W)) u_used_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(u_waddr),
    .wdata_i(u_wdata),
    .raddr_i(u_raddr),
    .rdata_o(u_rdata)
  );

  assign use_used  = (cmd_q != ffca_pkg::CMD_ALLOC);
  assign list_cnt  = use_used ? PW'(used_cnt_q) : PW'(free_cnt_q);
  assign scan_p1   = PW'(scan_q + 1'b1);
  assign scan_p2   = PW'(scan_q + 2'd2);
  assign free_full = (free_cnt_q == FCW'(ffca_pkg::FREE_ENTRIES));
  assign used_full = (used_cnt_q == UCW'(ffca_pkg::USED_ENTRIES));
  assign rd_ent    = use_used ? u_rdata : f_rdata;
  assign rd_ptr    = (state_q == S_CMP_RD) ? scan_p1 : scan_q;
  assign f_raddr   = rd_ptr[FIW-1:0];
  assign u_raddr   = rd_ptr[UIW-1:0];
  assign new_cls   = ffca_pkg::class_for(req_q);
  assign new_cap   = ffca_pkg::class_bytes(new_cls);
  assign new_end   = {1'b0, brk_q} + {23'd0, new_cap};

  always_comb begin
    case (cmd_q)
      ffca_pkg::CMD_ALLOC:     hit = (ffca_pkg::class_bytes(rd_ent.cls) >= req_q);
      ffca_pkg::CMD_FREE_ADDR: hit = (rd_ent.base == addr_q);
      default:                 hit = 1'b1;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    req_d        = req_q;
    addr_d       = addr_q;
    scan_d       = scan_q;
    free_cnt_d   = free_cnt_q;
    used_cnt_d   = used_cnt_q;
    heap_base_d  = heap_base_q;
    heap_limit_d = heap_limit_q;
    brk_d        = brk_q;
    ent_d        = ent_q;
    res_addr_d   = res_addr_q;
    res_bytes_d  = res_bytes_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_bytes_d  = out_bytes_q;
    out_st_d     = out_st_q;
    f_we         = 1'b0;
    f_waddr      = scan_q[FIW-1:0];
    f_wdata      = rd_ent;
    u_we         = 1'b0;
    u_waddr      = scan_q[UIW-1:0];
    u_wdata      = rd_ent;

    if (cfg_we_i) begin
      case (cfg_index_i)
        ffca_pkg::REG_HEAP_BASE: begin
          heap_base_d = cfg_data_i;
          brk_d       = cfg_data_i;
        end
        ffca_pkg::REG_HEAP_LIMIT: heap_limit_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          req_d       = request_bytes_i;
          addr_d      = chunk_address_i;
          scan_d      = '0;
          res_addr_d  = '0;
          res_bytes_d = '0;
          res_st_d    = ffca_pkg::ST_NOT_ALLOCATED;
          state_d     = S_RESP;
          case (command_i)
            ffca_pkg::CMD_ALLOC: begin
              if (request_bytes_i > ffca_pkg::MAX_REQUEST) begin
                res_st_d = ffca_pkg::ST_TOO_LARGE;
              end else if (used_full) begin
                res_st_d = ffca_pkg::ST_TABLE_FULL;
              end else if (free_cnt_q == '0) begin
                state_d = S_BUMP;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            ffca_pkg::CMD_FREE_ADDR: begin
              if (used_cnt_q != '0) begin
                state_d = S_SCAN_RD;
              end
            end
            ffca_pkg::CMD_FREE_LAST: begin
              if (used_cnt_q == '0) begin
                res_st_d = ffca_pkg::ST_NOT_ALLOCATED;
              end else if (free_full) begin
                res_st_d = ffca_pkg::ST_TABLE_FULL;
              end else begin
                scan_d  = PW'(used_cnt_q - 1'b1);
                state_d = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CK;
      S_SCAN_CK: begin
        if (hit) begin
          ent_d = rd_ent;
          if (cmd_q == ffca_pkg::CMD_FREE_ADDR && free_full) begin
            res_st_d = ffca_pkg::ST_TABLE_FULL;
            state_d  = S_RESP;
          end else if (scan_p1 < list_cnt) begin
            state_d = S_CMP_RD;
          end else begin
            state_d = S_PUSH;
          end
        end else begin
          scan_d = scan_p1;
          if (scan_p1 < list_cnt) begin
            state_d = S_SCAN_RD;
          end else if (cmd_q == ffca_pkg::CMD_ALLOC) begin
            state_d = S_BUMP;
          end else begin
            res_st_d = ffca_pkg::ST_NOT_ALLOCATED;
            state_d  = S_RESP;
          end
        end
      end
      S_CMP_RD: state_d = S_CMP_WR;
      S_CMP_WR: begin
        f_we   = !use_used;
        u_we   = use_used;
        scan_d = scan_p1;
        state_d = (scan_p2 < list_cnt) ? S_CMP_RD : S_PUSH;
      end
      S_PUSH: begin
        res_addr_d  = ent_q.base;
        res_bytes_d = ffca_pkg::class_bytes(ent_q.cls);
        res_st_d    = ffca_pkg::ST_OK;
        state_d     = S_RESP;
        if (cmd_q == ffca_pkg::CMD_ALLOC) begin
          free_cnt_d = FCW'(free_cnt_q - 1'b1);
          u_we       = 1'b1;
          u_waddr    = used_cnt_q[UIW-1:0];
          u_wdata    = ent_q;
          used_cnt_d = UCW'(used_cnt_q + 1'b1);
        end else begin
          used_cnt_d = UCW'(used_cnt_q - 1'b1);
          f_we       = 1'b1;
          f_waddr    = free_cnt_q[FIW-1:0];
          f_wdata    = ent_q;
          free_cnt_d = FCW'(free_cnt_q + 1'b1);
        end
      end
      S_BUMP: begin
        state_d = S_RESP;
        if (new_end > {1'b0, heap_limit_q}) begin
          res_st_d = ffca_pkg::ST_EXHAUSTED;
        end else begin
          u_we         = 1'b1;
          u_waddr      = used_cnt_q[UIW-1:0];
          u_wdata.base = brk_q;
          u_wdata.cls  = new_cls;
          used_cnt_d   = UCW'(used_cnt_q + 1'b1);
          brk_d        = new_end[31:0];
          res_addr_d   = brk_q;
          res_bytes_d  = new_cap;
          res_st_d     = ffca_pkg::ST_OK;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_bytes_d = res_bytes_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_cnt_q   <= '0;
      used_cnt_q   <= '0;
      heap_base_q  <= 32'd0;
      heap_limit_q <= 32'd65536;
      brk_q        <= 32'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_cnt_q   <= free_cnt_d;
      used_cnt_q   <= used_cnt_d;
      heap_base_q  <= heap_base_d;
      heap_limit_q <= heap_limit_d;
      brk_q        <= brk_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    addr_q      <= addr_d;
    scan_q      <= scan_d;
    ent_q       <= ent_d;
    res_addr_q  <= res_addr_d;
    res_bytes_q <= res_bytes_d;
    res_st_q    <= res_st_d;
    out_addr_q  <= out_addr_d;
    out_bytes_q <= out_bytes_d;
    out_st_q    <= out_st_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign chunk_bytes_o     = out_bytes_q;
  assign status_o          = out_st_q;

endmodule

/* rtl/core/ffca_list_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM holding one allocator list.
// Read data is registered and appears in the cycle after the address. No dependencies.
module ffca_list_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 35
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sim/tb_first_fit_chunk_allocator.sv */
`timescale 1ns / 1ps
// Testbench of the first-fit chunk allocator: a directed table, then random commands.
// Results are checked against a behavioural model of the two lists; depends on ffca_pkg.
module tb_first_fit_chunk_allocator;

  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  req;
    logic [31:0] addr;
    bit          fixed;
    logic [31:0] x_addr;
    logic [9:0]  x_bytes;
    logic [2:0]  x_status;
  } row_t;

  typedef struct {
    logic [31:0] addr;
    logic [9:0]  bytes;
    logic [2:0]  status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [9:0]  request_bytes_i = '0;
  logic [31:0] chunk_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] granted_address_o;
  logic [9:0]  chunk_bytes_o;
  logic [2:0]  status_o;

  first_fit_chunk_allocator u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] m_base, m_limit, m_brk;
  logic [31:0] free_addr[$], used_addr[$];
  logic [2:0]  free_cls[$], used_cls[$];
  answer_t     pending_answers[$];
  int          mismatches = 0;
  int          send_idle = 0, recv_stall = 0;

  function automatic answer_t allocator_answer(logic [1:0] cmd, logic [9:0] req,
                                               logic [31:0] addr);
    answer_t a;
    logic [2:0] c;
    logic [9:0] cap;
    a = '{32'd0, 10'd0, ffca_pkg::ST_NOT_ALLOCATED};
    if (cmd == ffca_pkg::CMD_ALLOC) begin
      if (req > 10'd512) begin
        a.status = ffca_pkg::ST_TOO_LARGE;
        return a;
      end
      if (used_addr.size() >= ffca_pkg::USED_ENTRIES) begin
        a.status = ffca_pkg::ST_TABLE_FULL;
        return a;
      end
      for (int i = 0; i < free_addr.size(); i++) begin
        if ((11'd32 << free_cls[i]) >= req) begin
          a = '{free_addr[i], 10'd32 << free_cls[i], ffca_pkg::ST_OK};
          used_addr = {used_addr, free_addr[i]};
          used_cls = {used_cls, free_cls[i]};
          free_addr.delete(i);
          free_cls.delete(i);
          return a;
        end
      end
      c = 0;
      while (c < 4 && (11'd32 << c) < req) c++;
      cap = 10'd32 << c;
      if ({1'b0, m_brk} + cap > {1'b0, m_limit}) begin
        a.status = ffca_pkg::ST_EXHAUSTED;
        return a;
      end
      a = '{m_brk, cap, ffca_pkg::ST_OK};
      used_addr = {used_addr, m_brk};
      used_cls = {used_cls, c};
      m_brk = m_brk + cap;
      return a;
    end
    if (cmd == ffca_pkg::CMD_FREE_ADDR || cmd == ffca_pkg::CMD_FREE_LAST) begin
      int k;
      k = -1;
      if (cmd == ffca_pkg::CMD_FREE_LAST) k = used_addr.size() - 1;
      else foreach (used_addr[i]) if (k < 0 && used_addr[i] == addr) k = i;
      if (k < 0) return a;
      if (free_addr.size() >= ffca_pkg::FREE_ENTRIES) begin
        a.status = ffca_pkg::ST_TABLE_FULL;
        return a;
      end
      a = '{used_addr[k], 10'd32 << used_cls[k], ffca_pkg::ST_OK};
      free_addr = {free_addr, used_addr[k]};
      free_cls = {free_cls, used_cls[k]};
      used_addr.delete(k);
      used_cls.delete(k);
    end
    return a;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffca_pkg::REG_HEAP_BASE) begin
      m_base = val;
      m_brk = val;
    end else begin
      m_limit = val;
    end
    @(posedge clk_i);
  endtask

  task automatic send_item(row_t r);
    answer_t a;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    a = allocator_answer(r.cmd, r.req, r.addr);
    if (r.fixed) a = '{r.x_addr, r.x_bytes, r.x_status};
    pending_answers = {pending_answers, a};
    in_valid_i <= 1'b1;
    command_i <= r.cmd;
    request_bytes_i <= r.req;
    chunk_address_i <= r.addr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %h %0d %0d",
                                       granted_address_o, chunk_bytes_o, status_o);
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        if (granted_address_o !== e.addr || chunk_bytes_o !== e.bytes ||
            status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %0d %0d, got %h %0d %0d", e.addr, e.bytes,
                     e.status, granted_address_o, chunk_bytes_o, status_o);
        end
      end
    end
  end

  function automatic row_t random_row();
    row_t r;
    int p;
    r.fixed = 0;
    r.x_addr = 0;
    r.x_bytes = 0;
    r.x_status = 0;
    p = $urandom_range(99);
    r.req = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(512));
    r.addr = $urandom;
    if (p < 50) r.cmd = ffca_pkg::CMD_ALLOC;
    else if (p < 80) begin
      r.cmd = ffca_pkg::CMD_FREE_ADDR;
      if (used_addr.size() != 0 && $urandom_range(3) != 0)
        r.addr = used_addr[$urandom_range(used_addr.size() - 1)];
    end else if (p < 97) r.cmd = ffca_pkg::CMD_FREE_LAST;
    else r.cmd = 2'd3;
    return r;
  endfunction

  row_t directed_rows[$];

  initial begin
    #5000000;
    $display("tb_first_fit_chunk_allocator: errors");
    $finish;
  end

  initial begin
    m_base = 0;
    m_limit = 65536;
    m_brk = 0;
    directed_rows = '{
      '{ffca_pkg::CMD_FREE_LAST, 10'd0, 32'd0, 1, 32'd0, 10'd0, ffca_pkg::ST_NOT_ALLOCATED},
      '{ffca_pkg::CMD_FREE_ADDR, 10'd0, 32'hFFFFFFFF, 1, 32'd0, 10'd0,
        ffca_pkg::ST_NOT_ALLOCATED},
      '{2'd3, 10'h3FF, 32'hFFFFFFFF, 1, 32'd0, 10'd0, ffca_pkg::ST_NOT_ALLOCATED},
      '{ffca_pkg::CMD_ALLOC, 10'd513, 32'd0, 1, 32'd0, 10'd0, ffca_pkg::ST_TOO_LARGE},
      '{ffca_pkg::CMD_ALLOC, 10'h3FF, 32'd0, 1, 32'd0, 10'd0, ffca_pkg::ST_TOO_LARGE},
      '{ffca_pkg::CMD_ALLOC, 10'd0, 32'd0, 1, 32'd0, 10'd32, ffca_pkg::ST_OK},
      '{ffca_pkg::CMD_ALLOC, 10'd512, 32'd0, 1, 32'd32, 10'd512, ffca_pkg::ST_OK},
      '{ffca_pkg::CMD_ALLOC, 10'd33, 32'd0, 0, 0, 0, 0},
      '{ffca_pkg::CMD_ALLOC, 10'd200, 32'd0, 0, 0, 0, 0},
      '{ffca_pkg::CMD_FREE_ADDR, 10'd0, 32'd32, 0, 0, 0, 0},
      '{ffca_pkg::CMD_FREE_LAST, 10'd0, 32'd0, 0, 0, 0, 0},
      '{ffca_pkg::CMD_ALLOC, 10'd1, 32'd0, 0, 0, 0, 0},
      '{ffca_pkg::CMD_ALLOC, 10'd300, 32'd0, 0, 0, 0, 0},
      '{ffca_pkg::CMD_ALLOC, 10'd0, 32'd0, 0, 0, 0, 0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    for (int i = 0; i < 18; i++) send_item('{ffca_pkg::CMD_ALLOC, 10'd16, 0, 0, 0, 0, 0});
    for (int i = 0; i < 18; i++) send_item('{ffca_pkg::CMD_FREE_LAST, 10'd0, 0, 0, 0, 0, 0});
    drain();
    write_reg(ffca_pkg::REG_HEAP_BASE, 32'hFFFFFE00);
    write_reg(ffca_pkg::REG_HEAP_LIMIT, 32'hFFFFFFFF);
    for (int i = 0; i < 3; i++) send_item('{ffca_pkg::CMD_ALLOC, 10'd256, 0, 0, 0, 0, 0});
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 72 : 19) : 0;
      recv_stall = (phase == 2) ? 72 : ((phase == 3) ? 19 : 0);
      write_reg(ffca_pkg::REG_HEAP_BASE, (phase == 0) ? 32'd0 : 32'($urandom) & 32'hFFFFF000);
      write_reg(ffca_pkg::REG_HEAP_LIMIT, (phase == 0) ? 32'd0 :
                (phase == 2) ? m_base + 32'd2048 : 32'hFFFFFFFF);
      for (int i = 0; i < 150; i++) send_item(random_row());
      drain();
    end
    if (mismatches == 0) $display("tb_first_fit_chunk_allocator: clean");
    else $display("tb_first_fit_chunk_allocator: errors");
    $finish;
  end
endmodule
